### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, suspended while reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/b64dec_pkg.sv
// Types, codes and the alphabet lookup for the Base64 decoder.
// No dependencies; used by every module of the decoder.
package b64dec_pkg;

    // Result status codes
    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_ERROR = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int unsigned MAX_RESULTS = 4;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } char_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       end_ok;
        logic       last_of_run;
    } result_item_t;

    // One queued result; last_of_run is added on the way out
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       end_ok;
    } entry_t;

    // All results raised by one transaction, handed to the emitter
    typedef struct packed {
        logic [2:0]                       count;
        entry_t [MAX_RESULTS-1:0]         entries;
    } bundle_t;

    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } sym_t;

    // Alphabet lookup: A-Z a-z 0-9 + /
    function automatic sym_t sym_lookup(input logic [7:0] c);
        sym_t r;
        logic [7:0] d;
        r.bad   = 1'b0;
        r.value = '0;
        d       = '0;
        if (c inside {[8'h41:8'h5A]}) begin
            d = c - 8'h41;
        end else if (c inside {[8'h61:8'h7A]}) begin
            d = c - 8'h61 + 8'd26;
        end else if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            d = 8'd62;
        end else if (c == 8'h2F) begin
            d = 8'd63;
        end else begin
            r.bad = 1'b1;
        end
        r.value = d[5:0];
        return r;
    endfunction

endpackage

### rtl/b64dec_decode.sv
// Group state and single-pass decode of one character into a result bundle.
// Depends on b64dec_pkg.
module b64dec_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  b64dec_pkg::char_item_t item,
    output b64dec_pkg::bundle_t    bundle
);
    import b64dec_pkg::*;

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic       err_reg;
    logic       err_next;
    logic [7:0] held_reg  [3];
    logic [7:0] held_next [3];

    sym_t       s0;
    sym_t       s1;
    sym_t       s2;
    sym_t       s3;
    logic       fail;
    logic [7:0] acc;
    logic [2:0] n;

    assign s0 = sym_lookup(held_reg[0]);
    assign s1 = sym_lookup(held_reg[1]);
    assign s2 = sym_lookup(held_reg[2]);
    assign s3 = sym_lookup(item.text_char);

    // Decode and next state
    always_comb
    begin
        bundle    = '0;
        n         = '0;
        fail      = 1'b0;
        acc       = '0;
        pos_next  = pos_reg;
        err_next  = err_reg;
        held_next = held_reg;
        if (!err_reg)
        begin
            if (pos_reg != 2'd3)
            begin
                held_next[pos_reg] = item.text_char;
                pos_next           = pos_reg + 2'd1;
            end
            else
            begin
                pos_next = '0;
                if (s0.bad || s1.bad)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    bundle.entries[n[1:0]] = '{{s0.value, s1.value[5:4]}, ST_DATA, 1'b0};
                    n   = n + 3'd1;
                    acc = {s1.value[3:0], 4'b0};
                    if (held_reg[2] != PAD_CHAR)
                    begin
                        if (s2.bad)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            bundle.entries[n[1:0]] =
                                '{{acc[7:4], s2.value[5:2]}, ST_DATA, 1'b0};
                            n   = n + 3'd1;
                            acc = {s2.value[1:0], 6'b0};
                        end
                    end
                    if (!fail && item.text_char != PAD_CHAR)
                    begin
                        if (s3.bad)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            bundle.entries[n[1:0]] =
                                '{acc | {2'b0, s3.value}, ST_DATA, 1'b0};
                            n = n + 3'd1;
                        end
                    end
                end
                if (fail)
                begin
                    bundle.entries[n[1:0]] = '{8'h00, ST_ERROR, 1'b0};
                    n        = n + 3'd1;
                    err_next = 1'b1;
                end
            end
        end
        // End of text: status and a fresh start
        if (item.end_of_text)
        begin
            bundle.entries[n[1:0]] = '{8'h00, ST_END, !err_next};
            n        = n + 3'd1;
            pos_next = '0;
            err_next = 1'b0;
        end
        bundle.count = n;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            err_reg <= err_next;
        end
    end

    // Held characters, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

### rtl/b64dec_emit.sv
// Result register: holds one bundle and hands out its results one per cycle while res_stall is low.
// Depends on b64dec_pkg.
module b64dec_emit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  b64dec_pkg::bundle_t      bundle,
    output logic                     free,
    output logic                     res_valid,
    input  logic                     res_stall,
    output b64dec_pkg::result_item_t res_data
);
    import b64dec_pkg::*;

    logic [2:0] rem_reg;
    logic [2:0] rem_next;
    entry_t     q_reg  [MAX_RESULTS];
    entry_t     q_next [MAX_RESULTS];
    logic       take;

    assign res_valid = (rem_reg != 3'd0);
    assign take      = res_valid && !res_stall;
    // Room for a new bundle once the last queued result leaves
    assign free      = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && take);

    assign res_data.out_byte    = q_reg[0].out_byte;
    assign res_data.status      = q_reg[0].status;
    assign res_data.end_ok      = q_reg[0].end_ok;
    assign res_data.last_of_run = (rem_reg == 3'd1);

    // Shift out on take, reload on a new bundle
    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        if (take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                q_next[i] = q_reg[i+1];
            end
            rem_next = rem_reg - 3'd1;
        end
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                q_next[i] = bundle.entries[i];
            end
            rem_next = bundle.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

### rtl/base64_decoder_core.sv
// Streaming Base64 decoder, top level.
// Depends on b64dec_pkg, b64dec_decode, b64dec_emit and assert_macros.svh.
//
//   channel | direction | payload       | handshake
//   char    | in        | char_item_t   | char_valid / char_stall
//   res     | out       | result_item_t | res_valid / res_stall
//
// One character is taken per cycle while char_stall is low; its results (up to
// four) leave one per cycle from the result register while res_stall is low, so
// a character raising several results holds the input until the last one leaves.
// Reset clears the group position, the error flag and the result queue.
// res_stall holds the queue; char_stall rises only while queued results remain.
`include "assert_macros.svh"

module base64_decoder_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     char_valid,
    output logic                     char_stall,
    input  b64dec_pkg::char_item_t   char_data,
    output logic                     res_valid,
    input  logic                     res_stall,
    output b64dec_pkg::result_item_t res_data
);
    import b64dec_pkg::*;

    logic    accept;
    logic    free;
    bundle_t bundle;

    assign char_stall = !free;
    assign accept     = char_valid && free;

    b64dec_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (char_data),
        .bundle (bundle)
    );

    b64dec_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .bundle    (bundle),
        .free      (free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // Input only held off while results are still queued
    `ASSERT_CLK(a_stall_needs_queue, char_stall |-> res_valid, "input stalled with empty queue")
    // End status always closes its run
    `ASSERT_CLK(a_end_is_last, (res_valid && res_data.status == ST_END) |-> res_data.last_of_run, "end status not last")
    // Only an end status carries end_ok
    `ASSERT_CLK(a_ok_only_end, (res_valid && res_data.end_ok) |-> (res_data.status == ST_END), "end_ok on non-end result")
    // Bundle never exceeds the queue depth
    `ASSERT_CLK(a_count_bound, accept |-> (bundle.count <= 3'd4), "bundle count overflow")

endmodule

### tb/decode_checker.sv
// Scoreboard for base64_decoder_core: tracks the char and res channels,
// predicts the decoded results and compares them. Depends on b64dec_pkg.
module decode_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     char_valid,
    input  logic                     char_stall,
    input  b64dec_pkg::char_item_t   char_data,
    input  logic                     res_valid,
    input  logic                     res_stall,
    input  b64dec_pkg::result_item_t res_data,
    output int                       mismatches,
    output int                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import b64dec_pkg::*;

    // Predictor state, mirrors the decoder's group and error tracking
    logic [1:0]   grp_pos;
    logic [7:0]   held_chars [3];
    bit           err_flag;

    // Results raised by the current character, and those still awaited
    result_item_t char_results [$];
    result_item_t awaited_results [$];

    // Alphabet position of one character; returns 0 when outside it
    function automatic bit alphabet_value(input logic [7:0] c, output logic [5:0] v);
        logic [7:0] d;
        bit         found;
        found = 1'b1;
        d     = '0;
        if (c >= 8'h41 && c <= 8'h5A)      // A-Z
            d = c - 8'h41;
        else if (c >= 8'h61 && c <= 8'h7A) // a-z
            d = c - 8'h61 + 8'd26;
        else if (c >= 8'h30 && c <= 8'h39) // 0-9
            d = c - 8'h30 + 8'd52;
        else if (c == 8'h2B)               // +
            d = 8'd62;
        else if (c == 8'h2F)               // /
            d = 8'd63;
        else
            found = 1'b0;
        v = d[5:0];
        return found;
    endfunction

    function void add_result(input logic [7:0] b, input logic [1:0] st, input logic ok);
        result_item_t r;
        r.out_byte    = b;
        r.status      = st;
        r.end_ok      = ok;
        r.last_of_run = 1'b0;
        char_results  = {char_results, r};
    endfunction

    // Repack a complete group; an invalid symbol stops it with an error result
    function void unpack_group(input logic [7:0] c3);
        logic [5:0] v0, v1, v2, v3;
        logic [7:0] acc;
        bit         bad;
        bad = !alphabet_value(held_chars[0], v0);
        if (!bad)
            bad = !alphabet_value(held_chars[1], v1);
        if (!bad) begin
            add_result({v0, v1[5:4]}, ST_DATA, 1'b0);
            acc = {v1[3:0], 4'b0000};
            if (held_chars[2] != PAD_CHAR) begin
                bad = !alphabet_value(held_chars[2], v2);
                if (!bad) begin
                    add_result(acc | {4'b0000, v2[5:2]}, ST_DATA, 1'b0);
                    acc = {v2[1:0], 6'b000000};
                end
            end
            // pad in third place: fourth value merges with the leftover bits
            if (!bad && c3 != PAD_CHAR) begin
                bad = !alphabet_value(c3, v3);
                if (!bad)
                    add_result(acc | {2'b00, v3}, ST_DATA, 1'b0);
            end
        end
        if (bad) begin
            add_result(8'h00, ST_ERROR, 1'b0);
            err_flag = 1'b1;
        end
    endfunction

    // Expected results of one accepted char transaction
    function void predict_decode(input char_item_t item);
        char_results.delete();
        if (!err_flag) begin
            if (grp_pos < 2'd3) begin
                held_chars[grp_pos] = item.text_char;
                grp_pos = grp_pos + 2'd1;
            end
            else begin
                grp_pos = 2'd0;
                unpack_group(item.text_char);
            end
        end
        if (item.end_of_text) begin
            add_result(8'h00, ST_END, !err_flag);
            grp_pos  = 2'd0;
            err_flag = 1'b0;
        end
        if (char_results.size() > 0)
            char_results[char_results.size() - 1].last_of_run = 1'b1;
        awaited_results = {awaited_results, char_results};
    endfunction

    // Compare one res transaction against the oldest expectation
    function void check_result(input result_item_t got);
        result_item_t want;
        if (awaited_results.size() == 0) begin
            if (mismatches < 10)
                $display("[%0t] unexpected result: byte %h status %0d ok %b last %b",
                         $realtime, got.out_byte, got.status, got.end_ok, got.last_of_run);
            mismatches++;
        end
        else begin
            want = awaited_results.pop_front();
            if (got.out_byte !== want.out_byte || got.status !== want.status ||
                got.end_ok !== want.end_ok || got.last_of_run !== want.last_of_run) begin
                if (mismatches < 10)
                    $display("[%0t] result mismatch: exp byte %h status %0d ok %b last %b,",
                             $realtime, want.out_byte, want.status, want.end_ok,
                             want.last_of_run,
                             " got byte %h status %0d ok %b last %b",
                             got.out_byte, got.status, got.end_ok, got.last_of_run);
                mismatches++;
            end
        end
    endfunction

    // Input side first: a result never belongs to the char taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            grp_pos  = 2'd0;
            err_flag = 1'b0;
            awaited_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else begin
            if (char_valid && !char_stall)
                predict_decode(char_data);
            if (res_valid && !res_stall)
                check_result(res_data);
            outstanding = awaited_results.size();
        end
    end

endmodule

### tb/testbench.sv
// Top of the base64_decoder_core bench: clock, reset, char stimulus and
// res back-pressure; scoring is done by decode_checker. Depends on b64dec_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import b64dec_pkg::*;

    localparam int HOLD_CYCLES  = 250;
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 8;
    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic         clk;
    logic         rst_n;
    logic         char_valid;
    logic         char_stall;
    char_item_t   char_data;
    logic         res_valid;
    logic         res_stall;
    result_item_t res_data;

    int           mismatches;
    int           outstanding;
    int           chars_sent;
    int           idle_pct;
    bit           calm;
    bit           hold_req;
    logic [7:0]   text_buf [$];

    base64_decoder_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    decode_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_data   (char_data),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("base64_decoder_core verification failed");
        $finish;
    end

    // Result back-pressure: random stall bursts, one long hold on request
    initial
    begin : res_pressure
        int stall_left;
        int stall_pct;
        int tick;
        bit hold_done;
        res_stall  = 1'b0;
        stall_left = 0;
        stall_pct  = 10;
        tick       = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge clk);
            tick++;
            if (tick % 32 == 0)
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
            if (stall_left == 0) begin
                if (hold_req && !hold_done) begin
                    stall_left = HOLD_CYCLES;
                    hold_done  = 1'b1;
                end
                else if (!calm && $urandom_range(0, 99) < stall_pct)
                    stall_left = $urandom_range(1, 18);
            end
            if (stall_left > 0) begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // Append one character to the text buffer
    function automatic void buf_char(input logic [7:0] c);
        text_buf = {text_buf, c};
    endfunction

    // Offer one char transaction, after an optional idle burst
    task automatic drive_char(input logic [7:0] c, input logic eot);
        char_item_t item;
        item.text_char   = c;
        item.end_of_text = eot;
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            @(negedge clk);
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clk);
        end
        @(negedge clk);
        char_valid <= 1'b1;
        char_data  <= item;
        @(posedge clk);
        while (char_stall) @(posedge clk);
        chars_sent++;
    endtask

    // Send the buffered text, end of text flagged on its last character
    task automatic send_text();
        foreach (text_buf[i])
            drive_char(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            buf_char(s[i]);
    endtask

    function automatic logic [7:0] alphabet_char();
        return ALPHABET[$urandom_range(0, 63)];
    endfunction

    // One random string: mostly well formed, some broken, some noise
    task automatic random_string();
        int kind;
        int groups;
        int pos;
        kind     = $urandom_range(0, 99);
        groups   = $urandom_range(1, 4);
        idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
        if (kind < 85) begin
            repeat (groups * 4) buf_char(alphabet_char());
            pos = text_buf.size();
            case ($urandom_range(0, 4))
                1: text_buf[pos - 1] = PAD_CHAR;
                2: begin
                    text_buf[pos - 1] = PAD_CHAR;
                    text_buf[pos - 2] = PAD_CHAR;
                end
                3: text_buf[pos - 2] = PAD_CHAR;   // pad followed by data
                default: ;
            endcase
            if (kind >= 70) begin
                // corrupt one character, sometimes leave a partial group
                pos = $urandom_range(0, text_buf.size() - 1);
                text_buf[pos] = ($urandom_range(0, 2) == 0) ? PAD_CHAR
                                                            : 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 0)
                    repeat ($urandom_range(1, 3)) buf_char(alphabet_char());
            end
        end
        else
            repeat ($urandom_range(1, 6)) buf_char(8'($urandom_range(0, 255)));
        send_text();
    endtask

    task automatic drain_results();
        @(negedge clk);
        char_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_data  = '0;
        chars_sent = 0;
        idle_pct   = 20;
        calm       = 1'b0;
        hold_req   = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: full group, padding forms, pad then data, alphabet edges
        load_text("TWFu");
        send_text();
        load_text("TQ==");
        send_text();
        load_text("TQ=A");
        send_text();
        load_text("Az+/");
        send_text();
        // invalid byte in second place, then ignored chars until end of text
        load_text("Q");
        buf_char(8'hFF);
        load_text("AABB");
        send_text();
        // partial group at end is dropped unchecked
        buf_char(8'h00);
        load_text("QQ");
        send_text();

        // Long receiver hold while chars keep coming
        hold_req = 1'b1;
        while (chars_sent < 45)
            random_string();

        // Sender waits for every result before carrying on
        drain_results();

        while (chars_sent < 92)
            random_string();
        calm = 1'b1;
        while (chars_sent < 112)
            random_string();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("base64_decoder_core verification clean");
        else
            $display("base64_decoder_core verification failed");
        $finish;
    end

endmodule
